FILE: hdl/hmmt_pkg.sv
// ----------------------------------------------------------------------------
// hmmt_pkg
// Shared constants and payload types of the histogram min/max tracker.
// ----------------------------------------------------------------------------
package hmmt_pkg;

	localparam int BINS       = 256;
	localparam int COUNT_BITS = 32;
	localparam int BIN_AW     = $clog2(BINS);
	localparam int VALUE_BITS = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);

	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                  mode;
		logic [VALUE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [31:0]           total_items;
		logic                  empty_res;
		logic [VALUE_BITS-1:0] least_value;
		logic [VALUE_BITS-1:0] greatest_value;
		logic [31:0]           least_count;
		logic [31:0]           greatest_count;
	} result_t;

endpackage

FILE: hdl/hmmt_ram.sv
// ----------------------------------------------------------------------------
// hmmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hmmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/histogram_min_max_tracker_unit.sv
// ----------------------------------------------------------------------------
// histogram_min_max_tracker_unit
// Histogram of 8-bit samples with add/delete and min/max bin statistics.
// ----------------------------------------------------------------------------
// Bin counts live in one BINS-entry RAM. An item reads its bin, writes back
// the new count, then sweeps every bin through the single RAM read port to
// find the least and greatest occupied values and the least nonzero and
// greatest counts. A new item is taken only once the previous one has
// finished its sweep over the read port and its result has been loaded into
// the output register; an out-of-range sample skips the bin update. After
// reset a clearing pass writes zero to every bin, during which no item is
// taken; configuration writes are taken at any time. The result sits in
// an output register, so an item may be taken while the previous result
// still waits.
module histogram_min_max_tracker_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  hmmt_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output hmmt_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hmmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmmt_pkg::VALUE_BITS-1:0] cfg_data
);

	import hmmt_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_MODIFY = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(BINS - 1);

	logic [2:0]             state_q;
	logic [BIN_AW-1:0]      addr_q;
	logic [VALUE_BITS-1:0]  range_low_q;
	logic [VALUE_BITS-1:0]  range_high_q;
	logic                   mode_q;
	logic [BIN_AW-1:0]      bin_q;
	logic [1:0]             status_q;
	logic [COUNT_BITS-1:0]  total_q;
	logic                   scan_v_s1;
	logic [BIN_AW-1:0]      scan_idx_s1;
	logic                   any_q;
	logic [BIN_AW-1:0]      lo_idx_q;
	logic [BIN_AW-1:0]      hi_idx_q;
	logic [COUNT_BITS-1:0]  peak_q;
	logic [COUNT_BITS-1:0]  floor_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   accept;
	logic                   in_range;
	logic [VALUE_BITS-1:0]  offset;
	logic                   wr_en;
	logic [BIN_AW-1:0]      wr_addr;
	logic [COUNT_BITS-1:0]  wr_data;
	logic                   rd_en;
	logic [BIN_AW-1:0]      rd_addr;
	logic [COUNT_BITS-1:0]  rd_data;
	logic                   load_result;

	assign accept       = item_valid && !item_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign load_result  = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	assign offset   = item.sample - range_low_q;
	assign in_range = (item.sample >= range_low_q) && (item.sample <= range_high_q) &&
		(32'(offset) < 32'(BINS));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = BIN_AW'(offset);
			end
			S_MODIFY: begin
				wr_addr = bin_q;
				if (mode_q == MODE_ADD) begin
					wr_en   = 1'b1;
					wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
				end else begin
					wr_en   = (rd_data != '0);
					wr_data = rd_data - 1'b1;
				end
			end
			S_SCAN: begin
				rd_en = 1'b1;
			end
			S_DRAIN, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	hmmt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BINS)
	) u_bins (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RANGE_LOW) begin
				range_low_q <= cfg_data;
			end else if (cfg_index == REG_RANGE_HIGH) begin
				range_high_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			addr_q    <= '0;
			total_q   <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_BIN) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= in_range ? S_MODIFY : S_SCAN;
					end
				end
				S_MODIFY: begin
					if (mode_q == MODE_ADD) begin
						if (total_q != COUNT_MAX) begin
							total_q <= total_q + 1'b1;
						end
					end else if (rd_data != '0 && total_q != '0) begin
						total_q <= total_q - 1'b1;
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_v_s1 <= 1'b1;
					addr_q    <= addr_q + 1'b1;
					if (addr_q == LAST_BIN) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_result) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= addr_q;
		if (accept) begin
			mode_q   <= item.mode;
			bin_q    <= BIN_AW'(offset);
			status_q <= in_range ? ST_OK : ST_RANGE;
			any_q    <= 1'b0;
			lo_idx_q <= '0;
			hi_idx_q <= '0;
			peak_q   <= '0;
			floor_q  <= COUNT_MAX;
		end
		if (state_q == S_MODIFY && mode_q == MODE_DELETE && rd_data == '0) begin
			status_q <= ST_EMPTY;
		end
		if (scan_v_s1 && rd_data != '0) begin
			if (!any_q) begin
				lo_idx_q <= scan_idx_s1;
			end
			hi_idx_q <= scan_idx_s1;
			any_q    <= 1'b1;
			if (rd_data > peak_q) begin
				peak_q <= rd_data;
			end
			if (rd_data < floor_q) begin
				floor_q <= rd_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q.status      <= status_q;
			result_q.total_items <= 32'(total_q);
			result_q.empty_res   <= !any_q;
			if (any_q) begin
				result_q.least_value    <= VALUE_BITS'(32'(range_low_q) + 32'(lo_idx_q));
				result_q.greatest_value <= VALUE_BITS'(32'(range_low_q) + 32'(hi_idx_q));
				result_q.least_count    <= 32'(floor_q);
				result_q.greatest_count <= 32'(peak_q);
			end else begin
				result_q.least_value    <= '0;
				result_q.greatest_value <= '0;
				result_q.least_count    <= '0;
				result_q.greatest_count <= '0;
			end
		end
	end

endmodule
